@@ rtl/arp_pkg.sv @@
`timescale 1ns / 1ps
package arp_pkg;

   localparam int unsigned NOTE_W     = 7;
   localparam int unsigned DUR_W      = 16;
   localparam int unsigned CNT_W      = 13;
   localparam int unsigned OFF_W      = 12;
   localparam int unsigned TOTAL_W    = 17;
   localparam int unsigned OFFCALC_W  = 18;
   localparam int unsigned DIV_STEP_W = 5;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [DUR_W-1:0] DURATION_RESET = 16'd24000;

   localparam logic [0:0] REG_NOTE_DURATION = 1'b0;

   localparam logic [1:0] ACT_PRESS   = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_BLOCK   = 2'd2;

   typedef struct packed {
      logic [1:0]        action;
      logic [NOTE_W-1:0] note_number;
      logic [CNT_W-1:0]  num_samples;
   } req_type;

   typedef struct packed {
      logic              is_note_on;
      logic [NOTE_W-1:0] out_note;
      logic [OFF_W-1:0]  sample_offset;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic ptr_inc;
      logic rd_ptr;
      logic shf_top;
      logic shf_next;
      logic rd_shf_lo;
      logic rd_shf;
      logic wr_up;
      logic wr_down;
      logic wr_ins;
      logic cnt_dec;
      logic blk_setup;
      logic div_time;
      logic time_store;
      logic div_idx;
      logic idx_store;
      logic emit_off;
      logic emit_on;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       scan_end;
      logic       shf_at_ptr;
      logic       shf_at_end;
      logic       rd_eq;
      logic       rd_gt;
      logic       full;
      logic       div_done;
      logic       fire;
      logic       count_zero;
      logic       snd_valid;
   } stat_type;

endpackage

@@ rtl/arp_rem_div.sv @@
`timescale 1ns / 1ps
module arp_rem_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [arp_pkg::TOTAL_W-1:0]   dividend,
   input  logic [arp_pkg::DUR_W-1:0]     divisor,
   output logic                          done,
   output logic [arp_pkg::DUR_W-1:0]     remainder
);

   logic [arp_pkg::TOTAL_W-1:0]    num_ff, num_in;
   logic [arp_pkg::DUR_W-1:0]      den_ff, den_in;
   logic [arp_pkg::DUR_W-1:0]      rem_ff, rem_in;
   logic [arp_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [arp_pkg::TOTAL_W-1:0]    trial;
   logic [arp_pkg::TOTAL_W-1:0]    diff;

   always_comb begin
      trial   = {rem_ff, num_ff[arp_pkg::TOTAL_W-1]};
      diff    = trial - {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         step_in = 5'(arp_pkg::TOTAL_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         num_in  = {num_ff[arp_pkg::TOTAL_W-2:0], 1'b0};
         rem_in  = (trial >= {1'b0, den_ff}) ? diff[arp_pkg::DUR_W-1:0]
                                             : trial[arp_pkg::DUR_W-1:0];
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/arp_datapath.sv @@
`timescale 1ns / 1ps
module arp_datapath #(
   parameter int unsigned MAX_HELD  = 16,
   parameter int unsigned MAX_BLOCK = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  arp_pkg::cmd_type            cmd,
   output arp_pkg::stat_type           stat,
   input  arp_pkg::req_type            req_data,
   input  logic                        cfg_we,
   input  logic [arp_pkg::DUR_W-1:0]   cfg_wdata,
   output logic [arp_pkg::DUR_W-1:0]   cfg_duration,
   output logic                        rsp_strobe,
   output arp_pkg::rsp_type            rsp_data
);

   localparam int unsigned IW = $clog2(MAX_HELD);
   localparam int unsigned CW = $clog2(MAX_HELD + 1);
   localparam logic signed [arp_pkg::OFFCALC_W-1:0] OFF_CAP =
      arp_pkg::OFFCALC_W'(MAX_BLOCK - 1);

   logic [arp_pkg::NOTE_W-1:0] held_mem [MAX_HELD];

   logic [arp_pkg::DUR_W-1:0]   dur_ff, dur_in;
   logic [1:0]                  action_ff, action_in;
   logic [arp_pkg::NOTE_W-1:0]  note_ff, note_in;
   logic [arp_pkg::CNT_W-1:0]   samples_ff, samples_in;
   logic [CW-1:0]               ptr_ff, ptr_in;
   logic [CW-1:0]               shf_ff, shf_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [IW-1:0]               step_ff, step_in;
   logic [arp_pkg::NOTE_W-1:0]  snd_note_ff, snd_note_in;
   logic                        snd_valid_ff, snd_valid_in;
   logic [arp_pkg::DUR_W-1:0]   time_ff, time_in;
   logic [arp_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                        fire_ff, fire_in;
   logic [arp_pkg::OFF_W-1:0]   off_ff, off_in;
   logic [arp_pkg::NOTE_W-1:0]  rd_data_ff;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   arp_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [arp_pkg::DUR_W-1:0]   dur_eff;
   logic [CW-1:0]               shf_lo;
   logic [CW-1:0]               idx_next;
   logic                        rd_en;
   logic [IW-1:0]               rd_addr;
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [arp_pkg::NOTE_W-1:0]  wr_data;
   logic                        div_start;
   logic [arp_pkg::TOTAL_W-1:0] div_dividend;
   logic [arp_pkg::DUR_W-1:0]   div_divisor;
   logic                        div_done;
   logic [arp_pkg::DUR_W-1:0]   div_rem;
   logic signed [arp_pkg::OFFCALC_W-1:0] off_diff;
   logic signed [arp_pkg::OFFCALC_W-1:0] off_hi;
   logic signed [arp_pkg::OFFCALC_W-1:0] off_a;
   logic signed [arp_pkg::OFFCALC_W-1:0] off_b;
   logic signed [arp_pkg::OFFCALC_W-1:0] off_c;

   assign dur_eff  = (dur_ff == '0) ? 16'd1 : dur_ff;
   assign shf_lo   = shf_ff - CW'(1);
   assign idx_next = CW'(step_ff) + CW'(1);

   assign div_start    = cmd.div_time | cmd.div_idx;
   assign div_dividend = cmd.div_idx ? 17'(idx_next) : total_ff;
   assign div_divisor  = cmd.div_idx ? 16'(count_ff) : dur_eff;

   arp_rem_div u_rem_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      off_diff = $signed({2'b00, dur_eff}) - $signed({2'b00, time_ff});
      off_hi   = $signed({5'b00000, samples_ff}) - 18'sd1;
      off_a    = (off_diff > off_hi) ? off_hi : off_diff;
      off_b    = (off_a < 18'sd0) ? 18'sd0 : off_a;
      off_c    = (off_b > OFF_CAP) ? OFF_CAP : off_b;
   end

   always_comb begin
      rd_en   = cmd.rd_ptr | cmd.rd_shf_lo | cmd.rd_shf | cmd.idx_store;
      rd_addr = ptr_ff[IW-1:0];
      priority if (cmd.rd_shf_lo) begin
         rd_addr = shf_lo[IW-1:0];
      end else if (cmd.rd_shf) begin
         rd_addr = shf_ff[IW-1:0];
      end else if (cmd.idx_store) begin
         rd_addr = div_rem[IW-1:0];
      end else begin
         rd_addr = ptr_ff[IW-1:0];
      end

      wr_en   = cmd.wr_up | cmd.wr_down | cmd.wr_ins;
      wr_data = cmd.wr_ins ? note_ff : rd_data_ff;
      priority if (cmd.wr_up) begin
         wr_addr = shf_ff[IW-1:0];
      end else if (cmd.wr_down) begin
         wr_addr = shf_lo[IW-1:0];
      end else begin
         wr_addr = ptr_ff[IW-1:0];
      end
   end

   always_comb begin
      dur_in        = cfg_we ? cfg_wdata : dur_ff;
      action_in     = action_ff;
      note_in       = note_ff;
      samples_in    = samples_ff;
      ptr_in        = ptr_ff;
      shf_in        = shf_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      snd_note_in   = snd_note_ff;
      snd_valid_in  = snd_valid_ff;
      time_in       = time_ff;
      total_in      = total_ff;
      fire_in       = fire_ff;
      off_in        = off_ff;
      rsp_strobe_in = cmd.emit_off | cmd.emit_on;
      rsp_data_in   = rsp_data_ff;

      if (cmd.load) begin
         action_in  = req_data.action;
         note_in    = req_data.note_number;
         samples_in = req_data.num_samples;
         ptr_in     = '0;
      end
      if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CW'(1);
      end

      priority if (cmd.shf_top) begin
         shf_in = count_ff;
      end else if (cmd.shf_next) begin
         shf_in = ptr_ff + CW'(1);
      end else if (cmd.wr_up) begin
         shf_in = shf_lo;
      end else if (cmd.wr_down) begin
         shf_in = shf_ff + CW'(1);
      end else begin
         shf_in = shf_ff;
      end

      if (cmd.wr_ins) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end

      if (cmd.blk_setup) begin
         total_in = {1'b0, time_ff} + 17'(samples_ff);
         fire_in  = total_in >= {1'b0, dur_eff};
         off_in   = off_c[arp_pkg::OFF_W-1:0];
      end
      if (cmd.time_store) begin
         time_in = div_rem;
      end
      if (cmd.idx_store) begin
         step_in = div_rem[IW-1:0];
      end

      if (cmd.emit_off) begin
         snd_valid_in = 1'b0;
      end
      if (cmd.emit_on) begin
         snd_valid_in = 1'b1;
         snd_note_in  = rd_data_ff;
      end

      if (rsp_strobe_in) begin
         rsp_data_in.is_note_on    = cmd.emit_on;
         rsp_data_in.out_note      = cmd.emit_on ? rd_data_ff : snd_note_ff;
         rsp_data_in.sample_offset = off_ff;
         rsp_data_in.last_of_run   = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         held_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= held_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff        <= arp_pkg::DURATION_RESET;
         count_ff      <= '0;
         step_ff       <= '0;
         snd_note_ff   <= '0;
         snd_valid_ff  <= 1'b0;
         time_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         dur_ff        <= dur_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         snd_note_ff   <= snd_note_in;
         snd_valid_ff  <= snd_valid_in;
         time_ff       <= time_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      action_ff   <= action_in;
      note_ff     <= note_in;
      samples_ff  <= samples_in;
      ptr_ff      <= ptr_in;
      shf_ff      <= shf_in;
      total_ff    <= total_in;
      fire_ff     <= fire_in;
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.action     = action_ff;
      stat.scan_end   = (ptr_ff == count_ff);
      stat.shf_at_ptr = (shf_ff == ptr_ff);
      stat.shf_at_end = (shf_ff == count_ff);
      stat.rd_eq      = (rd_data_ff == note_ff);
      stat.rd_gt      = (rd_data_ff > note_ff);
      stat.full       = (count_ff == CW'(MAX_HELD));
      stat.div_done   = div_done;
      stat.fire       = fire_ff;
      stat.count_zero = (count_ff == '0);
      stat.snd_valid  = snd_valid_ff;
   end

   assign cfg_duration = dur_ff;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

@@ rtl/arp_ctrl.sv @@
`timescale 1ns / 1ps
module arp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  arp_pkg::stat_type  stat,
   output arp_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_INS_RD,
      S_INS_WR,
      S_REM_RD,
      S_REM_WR,
      S_BLK,
      S_DIV_T,
      S_WAIT_T,
      S_DIV_I,
      S_WAIT_I,
      S_RD_I,
      S_EMIT_ON,
      S_EMIT_OFF
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      is_press;
   logic      is_scan;

   assign is_press = (stat.action == arp_pkg::ACT_PRESS);
   assign is_scan  = is_press || (stat.action == arp_pkg::ACT_RELEASE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (is_scan) begin
               state_in = S_SCAN_RD;
            end else if (stat.action == arp_pkg::ACT_BLOCK) begin
               state_in = S_BLK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               if (is_press && !stat.full) begin
                  cmd.shf_top = 1'b1;
                  state_in    = S_INS_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.rd_ptr = 1'b1;
               state_in   = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (stat.rd_eq) begin
               if (is_press) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.shf_next = 1'b1;
                  state_in     = S_REM_RD;
               end
            end else if (stat.rd_gt && is_press) begin
               if (stat.full) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.shf_top = 1'b1;
                  state_in    = S_INS_RD;
               end
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_INS_RD: begin
            if (stat.shf_at_ptr) begin
               cmd.wr_ins = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.rd_shf_lo = 1'b1;
               state_in      = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.wr_up = 1'b1;
            state_in  = S_INS_RD;
         end
         S_REM_RD: begin
            if (stat.shf_at_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_shf = 1'b1;
               state_in   = S_REM_WR;
            end
         end
         S_REM_WR: begin
            cmd.wr_down = 1'b1;
            state_in    = S_REM_RD;
         end
         S_BLK: begin
            cmd.blk_setup = 1'b1;
            state_in      = S_DIV_T;
         end
         S_DIV_T: begin
            cmd.div_time = 1'b1;
            state_in     = S_WAIT_T;
         end
         S_WAIT_T: begin
            if (stat.div_done) begin
               cmd.time_store = 1'b1;
               if (!stat.fire) begin
                  state_in = S_IDLE;
               end else if (!stat.count_zero) begin
                  state_in = S_DIV_I;
               end else if (stat.snd_valid) begin
                  state_in = S_EMIT_OFF;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DIV_I: begin
            cmd.div_idx = 1'b1;
            state_in    = S_WAIT_I;
         end
         S_WAIT_I: begin
            if (stat.div_done) begin
               cmd.idx_store = 1'b1;
               state_in      = S_RD_I;
            end
         end
         S_RD_I: begin
            cmd.emit_off = stat.snd_valid;
            state_in     = S_EMIT_ON;
         end
         S_EMIT_ON: begin
            cmd.emit_on   = 1'b1;
            cmd.emit_last = 1'b1;
            state_in      = S_IDLE;
         end
         S_EMIT_OFF: begin
            cmd.emit_off  = 1'b1;
            cmd.emit_last = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

@@ rtl/note_arpeggiator_core.sv @@
`timescale 1ns / 1ps
// Up-arpeggiator core.
// Input channel: a word on req_data is taken at a clock edge with start high
// and busy low. A press word adds its note, unless held already or the set is
// full, to an ascending set of held notes, a release word removes it, an
// end-of-block word advances the step timer by num_samples and may fire a step.
// Result channel: each event word sits on rsp_data for one cycle with
// rsp_strobe high; the receiver cannot hold it off. A fired step gives a
// note-off for the sounding note (if any), then a note-on for the next held
// note, in back-to-back cycles; last_of_run marks the final one.
// Sequencing: press and release walk the note memory, reading entries for the
// search and reading and writing each moved entry; searched and moved entries
// together never exceed the held count. End of block runs the remainder unit
// (17 steps, then a done strobe) for the timer and, when a step fires with
// notes held, again for the step index. One word is in work at a time.
// Configuration: APB register 0 (note_duration) at byte address 0.
// Reset: set empty, timer zero, no note sounding, duration 24000; the held
// note memory needs no clearing.
module note_arpeggiator_core #(
   parameter int unsigned MAX_HELD  = 16,
   parameter int unsigned MAX_BLOCK = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  arp_pkg::req_type                 req_data,
   output logic                             rsp_strobe,
   output arp_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [arp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [arp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [arp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   arp_pkg::cmd_type            cmd;
   arp_pkg::stat_type           stat;
   logic                        csr_we;
   logic                        csr_hit;
   logic [arp_pkg::DUR_W-1:0]   csr_duration;

   assign csr_hit = (paddr[arp_pkg::CSR_ADDR_W-1:2] == arp_pkg::REG_NOTE_DURATION);
   assign csr_we  = psel & penable & pwrite & csr_hit;
   assign prdata  = csr_hit ? 32'(csr_duration) : '0;
   assign pready  = 1'b1;

   arp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   arp_datapath #(
      .MAX_HELD  (MAX_HELD),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_data     (req_data),
      .cfg_we       (csr_we),
      .cfg_wdata    (pwdata[arp_pkg::DUR_W-1:0]),
      .cfg_duration (csr_duration),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule

@@ rtl/arp_checker.sv @@
`timescale 1ns / 1ps
module arp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  arp_pkg::req_type  req_data,
   input  logic              rsp_strobe,
   input  arp_pkg::rsp_type  rsp_data
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

   a_block_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == arp_pkg::ACT_BLOCK |=> busy)
      else $error("end-of-block word accepted without going busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("event word without work in progress");

   a_off_then_on: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_of_run |=>
         rsp_strobe && rsp_data.last_of_run && rsp_data.is_note_on)
      else $error("note-off not followed at once by the closing note-on");

   a_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.is_note_on |-> rsp_data.last_of_run)
      else $error("note-on not marked last");

endmodule

bind note_arpeggiator_core arp_checker u_arp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

@@ bench/tb_note_arpeggiator_core.sv @@
`timescale 1ns / 1ps
module tb_note_arpeggiator_core;

   localparam int HELD_MAX = 16;
   localparam int OFF_CAP = 4095;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASE_WORDS = 145;
   localparam int MAX_REPORTS = 40;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   arp_pkg::req_type req_data = '0;
   logic rsp_strobe;
   arp_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [arp_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [arp_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [arp_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   note_arpeggiator_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   // arpeggiator state as the bench sees it
   logic [arp_pkg::NOTE_W-1:0] held_set [HELD_MAX];
   int held_total = 0;
   int step_pos = 0;
   int step_time = 0;
   logic [arp_pkg::NOTE_W-1:0] playing_note = '0;
   bit playing = 1'b0;
   logic [arp_pkg::DUR_W-1:0] step_len = arp_pkg::DURATION_RESET;

   arp_pkg::rsp_type due_events[$];
   arp_pkg::req_type pending_words[$];
   arp_pkg::rsp_type oldest_event;

   int mismatches = 0;
   int idle_cycles = 0;
   logic taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic flag_mismatch(input string what);
      if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic play_word(input arp_pkg::req_type w);
      int pos;
      int i;
      int dur;
      int total;
      int offset;
      int fired;
      arp_pkg::rsp_type evs [2];
      pos = 0;
      fired = 0;
      case (w.action)
         arp_pkg::ACT_PRESS: begin
            while (pos < held_total && held_set[pos] < w.note_number) pos++;
            if (!(pos < held_total && held_set[pos] == w.note_number) &&
                held_total < HELD_MAX) begin
               for (i = held_total; i > pos; i--) held_set[i] = held_set[i-1];
               held_set[pos] = w.note_number;
               held_total++;
            end
         end
         arp_pkg::ACT_RELEASE: begin
            while (pos < held_total && held_set[pos] != w.note_number) pos++;
            if (pos < held_total) begin
               for (i = pos; i < held_total - 1; i++) held_set[i] = held_set[i+1];
               held_total--;
            end
         end
         arp_pkg::ACT_BLOCK: begin
            dur = (step_len == '0) ? 1 : int'(step_len);
            total = step_time + int'(w.num_samples);
            if (total >= dur) begin
               offset = dur - step_time;
               if (offset > int'(w.num_samples) - 1) offset = int'(w.num_samples) - 1;
               if (offset < 0) offset = 0;
               if (offset > OFF_CAP) offset = OFF_CAP;
               if (playing) begin
                  evs[fired] = '{1'b0, playing_note, offset[arp_pkg::OFF_W-1:0], 1'b0};
                  fired++;
                  playing = 1'b0;
               end
               if (held_total > 0) begin
                  step_pos = (step_pos + 1) % held_total;
                  playing_note = held_set[step_pos];
                  playing = 1'b1;
                  evs[fired] = '{1'b1, playing_note, offset[arp_pkg::OFF_W-1:0], 1'b0};
                  fired++;
               end
               for (i = 0; i < fired; i++) begin
                  if (i == fired - 1) evs[i].last_of_run = 1'b1;
                  due_events.push_back(evs[i]);
               end
            end
            step_time = total % dur;
         end
         default: ;
      endcase
   endtask

   task automatic queue_word(input logic [1:0] act, input int note, input int cnt);
      arp_pkg::req_type w;
      w.action = act;
      w.note_number = note[arp_pkg::NOTE_W-1:0];
      w.num_samples = cnt[arp_pkg::CNT_W-1:0];
      pending_words.push_back(w);
   endtask

   task automatic queue_random_words(input int n);
      int base;
      int k;
      int pick;
      int note;
      int cnt;
      int sel;
      logic [1:0] act;
      base = $urandom_range(0, 104);
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         note = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                            : base + $urandom_range(0, 23);
         if (pick < 38) act = arp_pkg::ACT_PRESS;
         else if (pick < 62) act = arp_pkg::ACT_RELEASE;
         else if (pick < 97) act = arp_pkg::ACT_BLOCK;
         else act = ACT_UNUSED;
         sel = $urandom_range(0, 9);
         if (sel == 0) cnt = 0;
         else if (sel == 1) cnt = $urandom_range(4097, 8191);
         else if (sel < 6) cnt = $urandom_range(1, 64);
         else cnt = $urandom_range(1, 4096);
         queue_word(act, note, cnt);
      end
   endtask

   // hold until every word is taken and every event has come, then let the core settle
   task automatic drain_words();
      while (pending_words.size() != 0 || start || due_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step_len(input logic [arp_pkg::DUR_W-1:0] len);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {arp_pkg::REG_NOTE_DURATION, 2'b00};
      pwdata <= arp_pkg::CSR_DATA_W'(len);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      step_len = len;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[arp_pkg::DUR_W-1:0] !== len)
         flag_mismatch($sformatf("note_duration reads %0d, wrote %0d",
                                 prdata[arp_pkg::DUR_W-1:0], len));
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         // hold the word until it is taken
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else if (pending_words.size() != 0) begin
         start <= 1'b1;
         req_data <= pending_words.pop_front();
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60)
                                                   : $urandom_range(0, 3);
         end else begin
            burst_left--;
         end
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         taken <= start && !busy;
         if (start && !busy) play_word(req_data);
         if (rsp_strobe) begin
            if (due_events.size() == 0) begin
               flag_mismatch($sformatf("unexpected event on=%0b note=%0d off=%0d last=%0b",
                                       rsp_data.is_note_on, rsp_data.out_note,
                                       rsp_data.sample_offset, rsp_data.last_of_run));
            end else begin
               oldest_event = due_events.pop_front();
               if (rsp_data.is_note_on !== oldest_event.is_note_on)
                  flag_mismatch($sformatf("is_note_on %b, want %b",
                                          rsp_data.is_note_on, oldest_event.is_note_on));
               if (rsp_data.out_note !== oldest_event.out_note)
                  flag_mismatch($sformatf("out_note %0d, want %0d",
                                          rsp_data.out_note, oldest_event.out_note));
               if (rsp_data.sample_offset !== oldest_event.sample_offset)
                  flag_mismatch($sformatf("sample_offset %0d, want %0d",
                                          rsp_data.sample_offset,
                                          oldest_event.sample_offset));
               if (rsp_data.last_of_run !== oldest_event.last_of_run)
                  flag_mismatch($sformatf("last_of_run %b, want %b",
                                          rsp_data.last_of_run, oldest_event.last_of_run));
            end
         end
         if ((start && !busy) || rsp_strobe || psel) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int phase_len [12];
      int p;
      int i;
      phase_len = '{65535, 7, 1, 24000, 300, 2, 4096, 0, 65535, 1000, 50, 3};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_word(arp_pkg::ACT_BLOCK, 0, 0);
      queue_word(arp_pkg::ACT_PRESS, 0, 0);
      queue_word(arp_pkg::ACT_PRESS, 127, 8191);
      queue_word(arp_pkg::ACT_PRESS, 64, 0);
      queue_word(arp_pkg::ACT_PRESS, 64, 0);
      queue_word(arp_pkg::ACT_RELEASE, 99, 0);
      queue_word(ACT_UNUSED, $urandom_range(0, 127), $urandom_range(0, 8191));
      queue_word(arp_pkg::ACT_BLOCK, 127, 8191);
      queue_word(arp_pkg::ACT_BLOCK, 0, 8191);
      queue_word(arp_pkg::ACT_BLOCK, 0, 8191);
      drain_words();

      write_step_len('0);
      queue_word(arp_pkg::ACT_BLOCK, 0, 0);
      queue_word(arp_pkg::ACT_RELEASE, 127, 0);
      queue_word(arp_pkg::ACT_BLOCK, 0, 1);
      queue_word(arp_pkg::ACT_RELEASE, 64, 0);
      queue_word(arp_pkg::ACT_RELEASE, 0, 0);
      queue_word(arp_pkg::ACT_BLOCK, 0, 1);
      queue_word(arp_pkg::ACT_PRESS, 0, 0);
      queue_word(arp_pkg::ACT_BLOCK, 0, 1);
      queue_word(arp_pkg::ACT_RELEASE, 0, 0);
      queue_word(arp_pkg::ACT_BLOCK, 0, 1);
      // fill the set, then press one more that must be dropped
      for (i = 0; i < HELD_MAX + 1; i++) queue_word(arp_pkg::ACT_PRESS, 10 + 7 * i, 0);
      queue_word(arp_pkg::ACT_BLOCK, 0, 1);
      queue_word(arp_pkg::ACT_BLOCK, 0, 1);
      drain_words();

      for (p = 0; p < 12; p++) begin
         write_step_len(phase_len[p][arp_pkg::DUR_W-1:0]);
         queue_random_words(PHASE_WORDS);
         drain_words();
      end

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
